@@ rtl/core/kpp_pkg.sv @@
// ---------------------------------------------------------------------------
// kpp_pkg
// Shared constants, types and helpers of the kinematic predictor with PID
// correction: defaults, register map and serial unit request/response types.
// ---------------------------------------------------------------------------
`default_nettype none

package kpp_pkg;

    // field geometry defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int VEL_EXTRA      = 16;

    // fixed field widths
    localparam int GAIN_BITS = 24;
    localparam int DT_BITS   = 20;
    localparam int ADDR_BITS = 4;
    localparam int MUL_B_BITS = 24;

    // reset values of the gains, unsigned Q8.16
    localparam logic [GAIN_BITS-1:0] KP_RESET = 24'd78643;
    localparam logic [GAIN_BITS-1:0] KI_RESET = 24'd197;
    localparam logic [GAIN_BITS-1:0] KD_RESET = 24'd983;

    // microseconds per second
    localparam logic [DT_BITS-1:0] US_PER_S = 20'd1000000;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_KP = 2'd0;
    localparam logic [1:0] REG_KI = 2'd1;
    localparam logic [1:0] REG_KD = 2'd2;

    // serial multiplier request and response
    typedef struct packed {
        logic                    start;
        logic [4:0]              nbits;
        logic signed [63:0]      a;
        logic signed [MUL_B_BITS:0] b;
    } kpp_mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } kpp_mul_rsp_t;

    // serial divider request and response
    typedef struct packed {
        logic                 start;
        logic signed [63:0]   dividend;
        logic [DT_BITS-1:0]   divisor;
    } kpp_div_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [63:0]   quot;
        logic signed [DT_BITS:0] rem;
    } kpp_div_rsp_t;

    // saturate a signed value to a narrower signed range
    function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                                 input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/kinematic_predictor_pid_correction_unit.sv @@
// ---------------------------------------------------------------------------
// kinematic_predictor_pid_correction_unit
// Constant-acceleration x predictor with PID correction for one tracked
// object, computed on a shared bit-serial multiplier and divider.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | in_valid / in_ready  | object_present, center_x, elapsed_us
//  out      | out_valid / out_ready| predicted_x, error_x, correction_active
//  config   | APB psel/penable     | paddr, pwdata, prdata (gains)
//
//  An active item runs five 64-step divisions and nine 20- or 24-step
//  multiplications one after another on the serial units; fewer when the
//  derivative clips. An item with no correction (first sighting, object
//  lost) goes from decode straight to the output without the serial units.
//  One item is worked on at a time; in_ready is high only while idle.
//  A finished result waits in the output register while the next item runs.
//  Reset clears all tracking state and loads the default gains.
// ---------------------------------------------------------------------------
`default_nettype none

module kinematic_predictor_pid_correction_unit
    import kpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  object_present,
    input  wire logic [COORD_BITS-1:0] center_x,
    input  wire logic [DT_BITS-1:0]    elapsed_us,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         predicted_x,
    output logic signed [23:0]         error_x,
    output logic                       correction_active,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_V, ST_KIN1, ST_KIN2, ST_EI, ST_P,
        ST_I1, ST_I2, ST_I3, ST_I4, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5,
        ST_SUM, ST_PRED, ST_OUT
    } state_t;

    localparam logic signed [63:0] D_LIM = 64'sd1 <<< 43;
    localparam logic signed [63:0] D_SAT = 64'sd1 <<< 62;

    state_t state_reg, state_next;
    logic   launched_reg, launched_next;

    logic [GAIN_BITS-1:0] kp_reg, kp_next, ki_reg, ki_next, kd_reg, kd_next;

    logic                   have_prev_reg, have_prev_next;
    logic [COORD_BITS-1:0]  prev_x_reg, prev_x_next;
    logic signed [39:0]     prev_vel_reg, prev_vel_next;
    logic signed [31:0]     prev_pred_reg, prev_pred_next;
    logic signed [31:0]     last_kin_reg, last_kin_next;
    logic signed [23:0]     prev_err_reg, prev_err_next;
    logic signed [47:0]     integ_reg, integ_next;

    logic                   present_reg, present_next;
    logic [COORD_BITS-1:0]  x_reg, x_next;
    logic [DT_BITS-1:0]     dt_reg, dt_next;
    logic signed [39:0]     vel_reg, vel_next;
    logic signed [23:0]     err_reg, err_next;
    logic signed [63:0]     t1_reg, t1_next;
    logic signed [31:0]     kin_reg, kin_next;
    logic signed [63:0]     p_reg, p_next;
    logic signed [63:0]     ia_reg, ia_next;
    logic signed [63:0]     i_reg, i_next;
    logic signed [63:0]     qt_reg, qt_next;
    logic signed [DT_BITS:0] rt_reg, rt_next;
    logic signed [63:0]     dm_reg, dm_next;
    logic                   dsat_reg, dsat_next;
    logic signed [63:0]     sum_reg, sum_next;

    logic signed [31:0]     res_pred_reg, res_pred_next;
    logic signed [23:0]     res_err_reg, res_err_next;
    logic                   res_act_reg, res_act_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [31:0]     out_pred_reg, out_pred_next;
    logic signed [23:0]     out_err_reg, out_err_next;
    logic                   out_act_reg, out_act_next;

    kpp_mul_req_t mreq;
    kpp_mul_rsp_t mrsp;
    kpp_div_req_t dreq;
    kpp_div_rsp_t drsp;

    logic signed [63:0] xs_w, dx_w;
    logic signed [63:0] vsat_w, esat_w, ksat_w, isat_w, psat_w, kin_full_w;
    logic signed [MUL_B_BITS:0] dt_b, ki_b, kd_b, us_b, err_b;
    logic cfg_wr;

    // shared serial units
    kpp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    kpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // operand forms
    assign xs_w  = $signed(64'(x_reg)) <<< FRAC_BITS;
    assign dx_w  = $signed(64'(x_reg)) - $signed(64'(prev_x_reg));
    assign dt_b  = $signed({5'd0, dt_reg});
    assign us_b  = $signed({5'd0, US_PER_S});
    assign ki_b  = $signed({1'b0, ki_reg});
    assign kd_b  = $signed({1'b0, kd_reg});
    assign err_b = (MUL_B_BITS+1)'(err_reg);

    // saturations taken at capture points
    assign vsat_w     = sat_s(drsp.quot, 40);
    assign esat_w     = sat_s(xs_w - 64'(prev_pred_reg), 24);
    assign kin_full_w = xs_w + t1_reg + (mrsp.res >>> (VEL_EXTRA + 1));
    assign ksat_w     = sat_s(kin_full_w, 32);
    assign isat_w     = sat_s(64'(integ_reg) + mrsp.res, 48);
    assign psat_w     = sat_s(64'(kin_reg) + (sum_reg >>> 16), 32);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_KP:  prdata = {8'd0, kp_reg};
            REG_KI:  prdata = {8'd0, ki_reg};
            REG_KD:  prdata = {8'd0, kd_reg};
            default: prdata = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_vel_next  = prev_vel_reg;
        prev_pred_next = prev_pred_reg;
        last_kin_next  = last_kin_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        present_next   = present_reg;
        x_next         = x_reg;
        dt_next        = dt_reg;
        vel_next       = vel_reg;
        err_next       = err_reg;
        t1_next        = t1_reg;
        kin_next       = kin_reg;
        p_next         = p_reg;
        ia_next        = ia_reg;
        i_next         = i_reg;
        qt_next        = qt_reg;
        rt_next        = rt_reg;
        dm_next        = dm_reg;
        dsat_next      = dsat_reg;
        sum_next       = sum_reg;
        res_pred_next  = res_pred_reg;
        res_err_next   = res_err_reg;
        res_act_next   = res_act_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_pred_next  = out_pred_reg;
        out_err_next   = out_err_reg;
        out_act_next   = out_act_reg;
        mreq           = '0;
        dreq           = '0;

        // gain writes
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_KP:  kp_next = pwdata[GAIN_BITS-1:0];
                REG_KI:  ki_next = pwdata[GAIN_BITS-1:0];
                REG_KD:  kd_next = pwdata[GAIN_BITS-1:0];
                default: kp_next = kp_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    present_next = object_present;
                    x_next       = center_x;
                    dt_next      = (elapsed_us == '0) ? DT_BITS'(1) : elapsed_us;
                    state_next   = ST_DECODE;
                end
            end

            // first sighting, lost object or active frame
            ST_DECODE:
            begin
                if (have_prev_reg && present_reg)
                begin
                    state_next = ST_V;
                end
                else
                begin
                    if (!have_prev_reg && present_reg)
                    begin
                        prev_x_next    = x_reg;
                        have_prev_next = 1'b1;
                    end
                    else if (have_prev_reg)
                    begin
                        have_prev_next = 1'b0;
                        prev_pred_next = '0;
                    end
                    integ_next    = '0;
                    res_pred_next = last_kin_reg;
                    res_err_next  = '0;
                    res_act_next  = 1'b0;
                    state_next    = ST_OUT;
                end
            end

            // velocity quotient and error
            ST_V:
            begin
                dreq.start    = ~launched_reg;
                dreq.dividend = dx_w <<< (FRAC_BITS + VEL_EXTRA);
                dreq.divisor  = dt_reg;
                launched_next = 1'b1;
                if (drsp.done)
                begin
                    vel_next      = vsat_w[39:0];
                    err_next      = esat_w[23:0];
                    launched_next = 1'b0;
                    state_next    = ST_KIN1;
                end
            end

            // v*dt
            ST_KIN1:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd20;
                mreq.a        = 64'(vel_reg);
                mreq.b        = dt_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    t1_next       = mrsp.res >>> VEL_EXTRA;
                    launched_next = 1'b0;
                    state_next    = ST_KIN2;
                end
            end

            // (v - v_prev)*dt and the kinematic sum
            ST_KIN2:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd20;
                mreq.a        = 64'(vel_reg) - 64'(prev_vel_reg);
                mreq.b        = dt_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    kin_next       = ksat_w[31:0];
                    prev_vel_next  = vel_reg;
                    prev_x_next    = x_reg;
                    prev_pred_next = ksat_w[31:0];
                    last_kin_next  = ksat_w[31:0];
                    launched_next  = 1'b0;
                    state_next     = ST_EI;
                end
            end

            // integral update
            ST_EI:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd20;
                mreq.a        = 64'(err_reg);
                mreq.b        = dt_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    integ_next    = isat_w[47:0];
                    launched_next = 1'b0;
                    state_next    = ST_P;
                end
            end

            // proportional term
            ST_P:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd24;
                mreq.a        = $signed(64'(kp_reg));
                mreq.b        = err_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    p_next        = mrsp.res;
                    launched_next = 1'b0;
                    state_next    = ST_I1;
                end
            end

            // integral split into seconds and remainder
            ST_I1:
            begin
                dreq.start    = ~launched_reg;
                dreq.dividend = 64'(integ_reg);
                dreq.divisor  = US_PER_S;
                launched_next = 1'b1;
                if (drsp.done)
                begin
                    qt_next       = drsp.quot;
                    rt_next       = drsp.rem;
                    launched_next = 1'b0;
                    state_next    = ST_I2;
                end
            end

            ST_I2:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd24;
                mreq.a        = qt_reg;
                mreq.b        = ki_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    ia_next       = mrsp.res;
                    launched_next = 1'b0;
                    state_next    = ST_I3;
                end
            end

            ST_I3:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd24;
                mreq.a        = 64'(rt_reg);
                mreq.b        = ki_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    qt_next       = mrsp.res;
                    launched_next = 1'b0;
                    state_next    = ST_I4;
                end
            end

            ST_I4:
            begin
                dreq.start    = ~launched_reg;
                dreq.dividend = qt_reg;
                dreq.divisor  = US_PER_S;
                launched_next = 1'b1;
                if (drsp.done)
                begin
                    i_next        = ia_reg + drsp.quot;
                    launched_next = 1'b0;
                    state_next    = ST_D1;
                end
            end

            // derivative: kd * change in error
            ST_D1:
            begin
                mreq.start    = ~launched_reg;
                mreq.nbits    = 5'd24;
                mreq.a        = 64'(err_reg) - 64'(prev_err_reg);
                mreq.b        = kd_b;
                launched_next = 1'b1;
                if (mrsp.done)
                begin
                    qt_next       = mrsp.res;
                    launched_next = 1'b0;
                    state_next    = ST_D2;
                end
            end

            ST_D2:
            begin
                dreq.start    = ~launched_reg;
                dreq.dividend = qt_reg;
                dreq.divisor  = dt_reg;
                launched_next = 1'b1;
                if (drsp.done)
                begin
                    qt_next       = drsp.quot;
                    rt_next       = drsp.rem;
                    launched_next = 1'b0;
                    state_next    = ST_D3;
                end
            end

            // whole quotient scaled to seconds, clipped when huge
            ST_D3:
            begin
                dsat_next = 1'b0;
                if (!launched_reg && (qt_reg > D_LIM))
                begin
                    dm_next    = D_SAT;
                    dsat_next  = 1'b1;
                    state_next = ST_D4;
                end
                else if (!launched_reg && (qt_reg < -D_LIM))
                begin
                    dm_next    = -D_SAT;
                    dsat_next  = 1'b1;
                    state_next = ST_D4;
                end
                else
                begin
                    mreq.start    = ~launched_reg;
                    mreq.nbits    = 5'd20;
                    mreq.a        = qt_reg;
                    mreq.b        = us_b;
                    launched_next = 1'b1;
                    if (mrsp.done)
                    begin
                        dm_next       = mrsp.res;
                        launched_next = 1'b0;
                        state_next    = ST_D4;
                    end
                end
            end

            ST_D4:
            begin
                if (dsat_reg)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    mreq.start    = ~launched_reg;
                    mreq.nbits    = 5'd20;
                    mreq.a        = 64'(rt_reg);
                    mreq.b        = us_b;
                    launched_next = 1'b1;
                    if (mrsp.done)
                    begin
                        qt_next       = mrsp.res;
                        launched_next = 1'b0;
                        state_next    = ST_D5;
                    end
                end
            end

            ST_D5:
            begin
                dreq.start    = ~launched_reg;
                dreq.dividend = qt_reg;
                dreq.divisor  = dt_reg;
                launched_next = 1'b1;
                if (drsp.done)
                begin
                    dm_next       = dm_reg + drsp.quot;
                    launched_next = 1'b0;
                    state_next    = ST_SUM;
                end
            end

            ST_SUM:
            begin
                sum_next   = p_reg + i_reg + dm_reg;
                state_next = ST_PRED;
            end

            ST_PRED:
            begin
                res_pred_next = psat_w[31:0];
                res_err_next  = err_reg;
                res_act_next  = 1'b1;
                prev_err_next = err_reg;
                state_next    = ST_OUT;
            end

            // hand the result over once the output register is free
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = res_pred_reg;
                    out_err_next   = res_err_reg;
                    out_act_next   = res_act_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            kp_reg        <= KP_RESET;
            ki_reg        <= KI_RESET;
            kd_reg        <= KD_RESET;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_vel_reg  <= '0;
            prev_pred_reg <= '0;
            last_kin_reg  <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            dsat_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_vel_reg  <= prev_vel_next;
            prev_pred_reg <= prev_pred_next;
            last_kin_reg  <= last_kin_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            dsat_reg      <= dsat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        present_reg  <= present_next;
        x_reg        <= x_next;
        dt_reg       <= dt_next;
        vel_reg      <= vel_next;
        err_reg      <= err_next;
        t1_reg       <= t1_next;
        kin_reg      <= kin_next;
        p_reg        <= p_next;
        ia_reg       <= ia_next;
        i_reg        <= i_next;
        qt_reg       <= qt_next;
        rt_reg       <= rt_next;
        dm_reg       <= dm_next;
        sum_reg      <= sum_next;
        res_pred_reg <= res_pred_next;
        res_err_reg  <= res_err_next;
        res_act_reg  <= res_act_next;
        out_pred_reg <= out_pred_next;
        out_err_reg  <= out_err_next;
        out_act_reg  <= out_act_next;
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign predicted_x       = out_pred_reg;
    assign error_x           = out_err_reg;
    assign correction_active = out_act_reg;

endmodule

`default_nettype wire

@@ rtl/core/kpp_mul.sv @@
// ---------------------------------------------------------------------------
// kpp_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add
// on magnitudes, sign applied in a final step. Low 64 bits of the product.
// ---------------------------------------------------------------------------
`default_nettype none

module kpp_mul
    import kpp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  kpp_mul_req_t      req,
    output kpp_mul_rsp_t      rsp
);

    logic                  busy_reg, busy_next;
    logic                  fix_reg, fix_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [63:0]           a_reg, a_next;
    logic [MUL_B_BITS-1:0] b_reg, b_next;
    logic [63:0]           acc_reg, acc_next;
    logic signed [63:0]    res_reg, res_next;
    logic [MUL_B_BITS:0]   b_mag;

    // magnitude of the multiplier operand
    assign b_mag = req.b[MUL_B_BITS] ? (MUL_B_BITS+1)'(-req.b) : req.b;

    // shift-add step
    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.a[63] ^ req.b[MUL_B_BITS];
            cnt_next  = req.nbits;
            a_next    = req.a[63] ? 64'(-req.a) : 64'(req.a);
            b_next    = b_mag[MUL_B_BITS-1:0];
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {1'b0, b_reg[MUL_B_BITS-1:1]};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            done_next = 1'b1;
            res_next  = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/kpp_div.sv @@
// ---------------------------------------------------------------------------
// kpp_div
// Bit-serial restoring divider: signed 64-bit dividend by a positive 20-bit
// divisor, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module kpp_div
    import kpp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  kpp_div_req_t      req,
    output kpp_div_rsp_t      rsp
);

    logic                    busy_reg, busy_next;
    logic                    fix_reg, fix_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic [63:0]             q_reg, q_next;
    logic [DT_BITS-1:0]      r_reg, r_next;
    logic [DT_BITS-1:0]      d_reg, d_next;
    logic signed [63:0]      quot_reg, quot_next;
    logic signed [DT_BITS:0] rem_reg, rem_next;
    logic [DT_BITS:0]        trial;
    logic [DT_BITS:0]        diff;

    // trial subtract of the shifted partial remainder
    assign trial = {r_reg, q_reg[63]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.dividend[63];
            cnt_next  = 7'd64;
            q_next    = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = diff[DT_BITS-1:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial[DT_BITS-1:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            done_next = 1'b1;
            quot_next = neg_reg ? -$signed(q_reg) : $signed(q_reg);
            rem_next  = neg_reg ? -$signed({1'b0, r_reg}) : $signed({1'b0, r_reg});
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire
